@@ sv/assert_macros.svh @@
// Assertion shorthands; clk_i and rst_ni must exist in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASRT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASRT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/irpdt_pkg.sv @@
`timescale 1ns / 1ps

package irpdt_pkg;

  localparam int CODE_BITS = 8;
  localparam int BIDX_W    = $clog2(CODE_BITS + 1);

  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEAD_MARK  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEAD_SPACE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BIT_MARK   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_BIT_SPACE  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_END_MARK   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_GAP        = 3'd6;

  localparam int UNIT_W = 9;
  localparam int TICK_W = 20;

  localparam logic [UNIT_W-1:0] LEADER_MARK_CYC    = 9'd280;
  localparam logic [UNIT_W-1:0] LEADER_SPACE_UNITS = 9'd140;
  localparam logic [UNIT_W-1:0] BIT_MARK_CYC       = 9'd23;
  localparam logic [UNIT_W-1:0] ONE_SPACE_UNITS    = 9'd64;
  localparam logic [UNIT_W-1:0] ZERO_SPACE_UNITS   = 9'd21;
  localparam logic [UNIT_W-1:0] END_MARK_CYC       = 9'd21;

  // Register map
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_ADDR_W-1:0] REG_CARRIER_HALF = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPACE_UNIT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TRAIL_GAP    = 2'd2;

  localparam logic [7:0]        RST_CARRIER_HALF = 8'd9;
  localparam logic [7:0]        RST_SPACE_UNIT   = 8'd20;
  localparam logic [TICK_W-1:0] RST_TRAIL_GAP    = 20'd200000;

  typedef struct packed {
    logic [7:0]        carrier_half;
    logic [7:0]        space_unit;
    logic [TICK_W-1:0] trail_gap;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase;
    logic [CODE_BITS-1:0] shift_code;
    logic [BIDX_W-1:0]    bit_idx;
    logic [UNIT_W-1:0]    unit_cnt;
    logic [TICK_W-1:0]    tick_cnt;
    logic                 carrier;
  } tx_state_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
  } tx_res_t;

endpackage

@@ sv/irpdt_cfg.sv @@
`timescale 1ns / 1ps

module irpdt_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [irpdt_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [irpdt_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output irpdt_pkg::cfg_t                     cfg_o
);

  irpdt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        irpdt_pkg::REG_CARRIER_HALF: cfg_d.carrier_half = cfg_wdata_i[7:0];
        irpdt_pkg::REG_SPACE_UNIT:   cfg_d.space_unit   = cfg_wdata_i[7:0];
        irpdt_pkg::REG_TRAIL_GAP:    cfg_d.trail_gap    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.carrier_half <= irpdt_pkg::RST_CARRIER_HALF;
      cfg_q.space_unit   <= irpdt_pkg::RST_SPACE_UNIT;
      cfg_q.trail_gap    <= irpdt_pkg::RST_TRAIL_GAP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/irpdt_step.sv @@
`timescale 1ns / 1ps

// One word's worth of frame sequencing: next state and result.
module irpdt_step (
  input  irpdt_pkg::tx_state_t  st_i,
  input  irpdt_pkg::cfg_t       cfg_i,
  input  logic                  op_i,
  input  logic [7:0]            code_i,
  output irpdt_pkg::tx_state_t  st_o,
  output irpdt_pkg::tx_res_t    res_o
);

  logic                         is_mark;
  logic                         nxt_mark;
  logic [7:0]                   half;
  logic [7:0]                   unit;
  logic [irpdt_pkg::TICK_W:0]   tick_inc;
  logic [irpdt_pkg::UNIT_W-1:0] unit_inc;
  logic [irpdt_pkg::UNIT_W-1:0] seg_len;
  logic [irpdt_pkg::BIDX_W-1:0] bidx_inc;
  logic [31:0]                  code_ext;
  logic                         seg_end;
  logic                         done;

  always_comb begin
    st_o     = st_i;
    done     = 1'b0;
    seg_end  = 1'b0;
    is_mark  = (st_i.phase == irpdt_pkg::PH_LEAD_MARK) ||
               (st_i.phase == irpdt_pkg::PH_BIT_MARK) ||
               (st_i.phase == irpdt_pkg::PH_END_MARK);
    half     = (cfg_i.carrier_half == 8'd0) ? 8'd1 : cfg_i.carrier_half;
    unit     = (cfg_i.space_unit == 8'd0) ? 8'd1 : cfg_i.space_unit;
    tick_inc = {1'b0, st_i.tick_cnt} + 1'b1;
    unit_inc = st_i.unit_cnt + 1'b1;
    bidx_inc = st_i.bit_idx + 1'b1;
    code_ext = 32'(code_i);

    case (st_i.phase)
      irpdt_pkg::PH_LEAD_MARK:  seg_len = irpdt_pkg::LEADER_MARK_CYC;
      irpdt_pkg::PH_LEAD_SPACE: seg_len = irpdt_pkg::LEADER_SPACE_UNITS;
      irpdt_pkg::PH_BIT_MARK:   seg_len = irpdt_pkg::BIT_MARK_CYC;
      irpdt_pkg::PH_BIT_SPACE:  seg_len = st_i.shift_code[0] ? irpdt_pkg::ONE_SPACE_UNITS
                                                             : irpdt_pkg::ZERO_SPACE_UNITS;
      default:                  seg_len = irpdt_pkg::END_MARK_CYC;
    endcase

    if (op_i) begin
      if (st_i.phase == irpdt_pkg::PH_IDLE) begin
        st_o.phase      = irpdt_pkg::PH_LEAD_MARK;
        st_o.shift_code = code_ext[irpdt_pkg::CODE_BITS-1:0];
        st_o.bit_idx    = '0;
        st_o.unit_cnt   = '0;
        st_o.tick_cnt   = '0;
        st_o.carrier    = 1'b1;
      end
    end else if (st_i.phase != irpdt_pkg::PH_IDLE) begin
      if (is_mark) begin
        if (tick_inc >= {13'd0, half}) begin
          st_o.tick_cnt = '0;
          if (st_i.carrier) begin
            st_o.carrier = 1'b0;
          end else begin
            // low half closes a carrier cycle
            st_o.carrier  = 1'b1;
            st_o.unit_cnt = unit_inc;
            seg_end       = (unit_inc >= seg_len);
          end
        end else begin
          st_o.tick_cnt = tick_inc[irpdt_pkg::TICK_W-1:0];
        end
      end else if (st_i.phase == irpdt_pkg::PH_GAP) begin
        st_o.tick_cnt = tick_inc[irpdt_pkg::TICK_W-1:0];
        seg_end       = (tick_inc >= {1'b0, cfg_i.trail_gap});
      end else begin
        if (tick_inc >= {13'd0, unit}) begin
          st_o.tick_cnt = '0;
          st_o.unit_cnt = unit_inc;
          seg_end       = (unit_inc >= seg_len);
        end else begin
          st_o.tick_cnt = tick_inc[irpdt_pkg::TICK_W-1:0];
        end
      end

      if (seg_end) begin
        st_o.unit_cnt = '0;
        st_o.tick_cnt = '0;
        st_o.carrier  = 1'b1;
        case (st_i.phase)
          irpdt_pkg::PH_LEAD_MARK:  st_o.phase = irpdt_pkg::PH_LEAD_SPACE;
          irpdt_pkg::PH_LEAD_SPACE: begin
            st_o.phase   = irpdt_pkg::PH_BIT_MARK;
            st_o.bit_idx = '0;
          end
          irpdt_pkg::PH_BIT_MARK:   st_o.phase = irpdt_pkg::PH_BIT_SPACE;
          irpdt_pkg::PH_BIT_SPACE: begin
            st_o.shift_code = st_i.shift_code >> 1;
            st_o.bit_idx    = bidx_inc;
            st_o.phase      = (bidx_inc >= irpdt_pkg::BIDX_W'(irpdt_pkg::CODE_BITS))
                              ? irpdt_pkg::PH_END_MARK : irpdt_pkg::PH_BIT_MARK;
          end
          irpdt_pkg::PH_END_MARK: begin
            st_o.carrier = 1'b0;
            if (cfg_i.trail_gap == '0) begin
              st_o.phase = irpdt_pkg::PH_IDLE;
              done       = 1'b1;
            end else begin
              st_o.phase = irpdt_pkg::PH_GAP;
            end
          end
          default: begin
            st_o.carrier = 1'b0;
            st_o.phase   = irpdt_pkg::PH_IDLE;
            done         = 1'b1;
          end
        endcase
      end
    end

    nxt_mark = (st_o.phase == irpdt_pkg::PH_LEAD_MARK) ||
               (st_o.phase == irpdt_pkg::PH_BIT_MARK) ||
               (st_o.phase == irpdt_pkg::PH_END_MARK);

    if (op_i) begin
      res_o.pin_level  = nxt_mark & st_o.carrier;
      res_o.busy_res   = (st_o.phase != irpdt_pkg::PH_IDLE);
      res_o.frame_done = 1'b0;
    end else begin
      res_o.pin_level  = is_mark & st_i.carrier;
      res_o.busy_res   = (st_i.phase != irpdt_pkg::PH_IDLE);
      res_o.frame_done = done;
    end
  end

endmodule

@@ sv/ir_pulse_distance_transmitter.sv @@
`timescale 1ns / 1ps
// Path: input register, sequencer, result register (once the slot is free).
// Throughput: one word per cycle; sequencer is one pass of logic between the
//   input register and the result register; a stalled result stalls input.
// Reset: async active low; sequencer idle, no words held, config regs back
//   to 9 / 20 / 200000 ticks.
module ir_pulse_distance_transmitter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [irpdt_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [irpdt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             in_op_i,
  input  logic [7:0]                       in_code_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             out_pin_level_o,
  output logic                             out_busy_res_o,
  output logic                             out_frame_done_o
);

  irpdt_pkg::cfg_t      cfg;
  irpdt_pkg::tx_state_t st_q, st_d;
  irpdt_pkg::tx_res_t   res_d, res_q;

  logic       in_valid_q;
  logic       op_q;
  logic [7:0] code_q;
  logic       out_valid_q;
  logic       adv;

  irpdt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  irpdt_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg),
    .op_i   (op_q),
    .code_i (code_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // result slot frees up when empty or being taken
  assign adv        = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = in_valid_q & ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
      if (in_valid_q && adv) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q   <= in_op_i;
      code_q <= in_code_i;
    end
    if (in_valid_q && adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_pin_level_o  = res_q.pin_level;
  assign out_busy_res_o   = res_q.busy_res;
  assign out_frame_done_o = res_q.frame_done;

endmodule

@@ sv/irpdt_chk.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irpdt_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic out_pin_level_o,
  input logic out_busy_res_o,
  input logic out_frame_done_o
);

  `ASRT_NXT(a_out_hold, out_valid_o && out_stall_i,
            out_valid_o && $stable(out_pin_level_o) && $stable(out_busy_res_o)
            && $stable(out_frame_done_o), "stalled result word changed")
  `ASRT_IMP(a_done_busy, out_valid_o && out_frame_done_o, out_busy_res_o, "frame_done without busy")
  `ASRT_IMP(a_idle_low, out_valid_o && !out_busy_res_o, !out_pin_level_o, "pin high while idle")
  `ASRT_IMP(a_no_stall_free, in_stall_o, out_valid_o && out_stall_i,
            "input stalled with free result slot")

endmodule

bind ir_pulse_distance_transmitter irpdt_chk u_irpdt_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_pin_level_o  (out_pin_level_o),
  .out_busy_res_o   (out_busy_res_o),
  .out_frame_done_o (out_frame_done_o)
);

@@ tb/tb_ir_pulse_distance_transmitter.sv @@
`timescale 1ns / 1ps

module tb_ir_pulse_distance_transmitter;

  localparam int      RESET_CYCLES = 11;
  localparam realtime LIMIT_NS     = 12_000_000.0;
  localparam logic    OP_TICK      = 1'b0;
  localparam logic    OP_SEND      = 1'b1;
  localparam int      DIR_ROWS     = 20;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             cfg_we_i    = 1'b0;
  logic [irpdt_pkg::CFG_ADDR_W-1:0] cfg_addr_i  = irpdt_pkg::REG_CARRIER_HALF;
  logic [irpdt_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_op_i     = OP_TICK;
  logic [7:0]                       in_code_i   = 8'h00;
  logic                             out_stall_i = 1'b0;
  logic                             in_stall_o;
  logic                             out_valid_o;
  logic                             out_pin_level_o;
  logic                             out_busy_res_o;
  logic                             out_frame_done_o;

  ir_pulse_distance_transmitter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_op_i         (in_op_i),
    .in_code_i       (in_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_pin_level_o (out_pin_level_o),
    .out_busy_res_o  (out_busy_res_o),
    .out_frame_done_o(out_frame_done_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted transmitter state and register copies
  logic [7:0]                    cfg_half   = irpdt_pkg::RST_CARRIER_HALF;
  logic [7:0]                    cfg_unit   = irpdt_pkg::RST_SPACE_UNIT;
  logic [irpdt_pkg::TICK_W-1:0]  cfg_gap    = irpdt_pkg::RST_TRAIL_GAP;
  logic [irpdt_pkg::PHASE_W-1:0] tx_phase   = irpdt_pkg::PH_IDLE;
  logic [7:0]                    tx_code    = 8'h00;
  int unsigned                   tx_bit     = 0;
  logic [irpdt_pkg::UNIT_W-1:0]  tx_units   = '0;
  logic [irpdt_pkg::TICK_W-1:0]  tx_ticks   = '0;
  logic                          tx_carrier = 1'b0;

  irpdt_pkg::tx_res_t pin_q[$];
  int                 frames_done = 0;
  int                 errors      = 0;
  bit                 steady      = 1'b0;

  typedef struct {
    logic               op;
    logic [7:0]         code;
    bit                 known;
    irpdt_pkg::tx_res_t res;  // {pin_level, busy_res, frame_done}
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_TICK, 8'h00, 1'b1, 3'b000},  // idle tick after reset
    '{OP_TICK, 8'hFF, 1'b1, 3'b000},  // code ignored on a tick
    '{OP_SEND, 8'h00, 1'b1, 3'b110},  // leader mark starts high
    '{OP_TICK, 8'h5A, 1'b1, 3'b110},
    '{OP_SEND, 8'hFF, 1'b0, 3'b000},  // request while busy
    '{OP_TICK, 8'h01, 1'b0, 3'b000},
    '{OP_TICK, 8'h02, 1'b0, 3'b000},
    '{OP_TICK, 8'h04, 1'b0, 3'b000},
    '{OP_TICK, 8'h08, 1'b0, 3'b000},
    '{OP_TICK, 8'h10, 1'b0, 3'b000},
    '{OP_TICK, 8'h20, 1'b0, 3'b000},
    '{OP_TICK, 8'h40, 1'b0, 3'b000},
    '{OP_TICK, 8'h80, 1'b0, 3'b000},
    '{OP_TICK, 8'hA5, 1'b0, 3'b000},  // first low half
    '{OP_SEND, 8'h81, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 3'b000},
    '{OP_TICK, 8'h7E, 1'b0, 3'b000},
    '{OP_TICK, 8'hFF, 1'b0, 3'b000},
    '{OP_TICK, 8'h3C, 1'b0, 3'b000},
    '{OP_TICK, 8'hC3, 1'b0, 3'b000}
  };

  function automatic void start_segment(input logic [irpdt_pkg::PHASE_W-1:0] ph);
    tx_phase   = ph;
    tx_units   = '0;
    tx_ticks   = '0;
    tx_carrier = 1'b1;
  endfunction

  function automatic bit in_mark(input logic [irpdt_pkg::PHASE_W-1:0] ph);
    return ph == irpdt_pkg::PH_LEAD_MARK || ph == irpdt_pkg::PH_BIT_MARK ||
           ph == irpdt_pkg::PH_END_MARK;
  endfunction

  function automatic logic [irpdt_pkg::UNIT_W-1:0] segment_units();
    case (tx_phase)
      irpdt_pkg::PH_LEAD_MARK:  return irpdt_pkg::LEADER_MARK_CYC;
      irpdt_pkg::PH_LEAD_SPACE: return irpdt_pkg::LEADER_SPACE_UNITS;
      irpdt_pkg::PH_BIT_MARK:   return irpdt_pkg::BIT_MARK_CYC;
      irpdt_pkg::PH_BIT_SPACE:
        return tx_code[0] ? irpdt_pkg::ONE_SPACE_UNITS : irpdt_pkg::ZERO_SPACE_UNITS;
      default:                  return irpdt_pkg::END_MARK_CYC;
    endcase
  endfunction

  // Moves past the finished segment; 1 when the frame is over
  function automatic logic advance_segment();
    case (tx_phase)
      irpdt_pkg::PH_LEAD_MARK: start_segment(irpdt_pkg::PH_LEAD_SPACE);
      irpdt_pkg::PH_LEAD_SPACE: begin
        tx_bit = 0;
        start_segment(irpdt_pkg::PH_BIT_MARK);
      end
      irpdt_pkg::PH_BIT_MARK: start_segment(irpdt_pkg::PH_BIT_SPACE);
      irpdt_pkg::PH_BIT_SPACE: begin
        tx_code = tx_code >> 1;
        tx_bit++;
        if (tx_bit >= irpdt_pkg::CODE_BITS) start_segment(irpdt_pkg::PH_END_MARK);
        else start_segment(irpdt_pkg::PH_BIT_MARK);
      end
      irpdt_pkg::PH_END_MARK: begin
        if (cfg_gap == '0) begin
          start_segment(irpdt_pkg::PH_IDLE);
          tx_carrier = 1'b0;
          return 1'b1;
        end
        start_segment(irpdt_pkg::PH_GAP);
        tx_carrier = 1'b0;
      end
      default: begin
        start_segment(irpdt_pkg::PH_IDLE);
        tx_carrier = 1'b0;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic irpdt_pkg::tx_res_t pin_step(input logic op, input logic [7:0] code);
    irpdt_pkg::tx_res_t r;
    logic [7:0]         half;
    logic [7:0]         unit;
    r = '0;
    half = (cfg_half == 8'd0) ? 8'd1 : cfg_half;
    unit = (cfg_unit == 8'd0) ? 8'd1 : cfg_unit;
    if (op == OP_SEND) begin
      if (tx_phase == irpdt_pkg::PH_IDLE) begin
        tx_code = code;
        tx_bit  = 0;
        start_segment(irpdt_pkg::PH_LEAD_MARK);
      end
      r.busy_res  = (tx_phase != irpdt_pkg::PH_IDLE);
      r.pin_level = in_mark(tx_phase) ? tx_carrier : 1'b0;
    end else if (tx_phase != irpdt_pkg::PH_IDLE) begin
      r.busy_res = 1'b1;
      if (in_mark(tx_phase)) begin
        r.pin_level = tx_carrier;
        tx_ticks++;
        if (tx_ticks >= half) begin
          tx_ticks = '0;
          if (tx_carrier) begin
            tx_carrier = 1'b0;
          end else begin
            // a carrier cycle ends on the low half
            tx_carrier = 1'b1;
            tx_units++;
            if (tx_units >= segment_units()) r.frame_done = advance_segment();
          end
        end
      end else if (tx_phase == irpdt_pkg::PH_GAP) begin
        tx_ticks++;
        if (tx_ticks >= cfg_gap) r.frame_done = advance_segment();
      end else begin
        tx_ticks++;
        if (tx_ticks >= unit) begin
          tx_ticks = '0;
          tx_units++;
          if (tx_units >= segment_units()) r.frame_done = advance_segment();
        end
      end
    end
    return r;
  endfunction

  // Mostly ticks while a frame runs, mostly requests while idle
  function automatic logic pick_op();
    if (tx_phase == irpdt_pkg::PH_IDLE) begin
      return ($urandom_range(0, 99) < 75) ? OP_SEND : OP_TICK;
    end
    return ($urandom_range(0, 99) < 2) ? OP_SEND : OP_TICK;
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Called just after a rising edge; returns just after the accepting edge
  task automatic send_word(input logic op, input logic [7:0] code, input bit known,
                           input irpdt_pkg::tx_res_t res);
    irpdt_pkg::tx_res_t r;
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_op_i    <= op;
    in_code_i  <= code;
    do @(posedge clk_i); while (in_stall_o);
    r = pin_step(op, code);
    if (r.frame_done) frames_done++;
    pin_q.push_back(known ? res : r);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pin_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_cfg(input logic [7:0] half, input logic [7:0] unit,
                          input logic [irpdt_pkg::TICK_W-1:0] gap_ticks);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= irpdt_pkg::REG_CARRIER_HALF;
    cfg_wdata_i <= irpdt_pkg::CFG_DATA_W'(half);
    @(posedge clk_i);
    cfg_addr_i  <= irpdt_pkg::REG_SPACE_UNIT;
    cfg_wdata_i <= irpdt_pkg::CFG_DATA_W'(unit);
    @(posedge clk_i);
    cfg_addr_i  <= irpdt_pkg::REG_TRAIL_GAP;
    cfg_wdata_i <= irpdt_pkg::CFG_DATA_W'(gap_ticks);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_half = half;
    cfg_unit = unit;
    cfg_gap  = gap_ticks;
  endtask

  task automatic run_words(input int frames, input int min_words, input int max_words);
    int n;
    int base;
    n    = 0;
    base = frames_done;
    while (n < max_words && (n < min_words || frames_done - base < frames)) begin
      send_word(pick_op(), pick_code(), 1'b0, '0);
      n++;
    end
  endtask

  task automatic run_to_phase(input logic [irpdt_pkg::PHASE_W-1:0] ph, input int max_words);
    int n;
    n = 0;
    while (n < max_words && tx_phase != ph) begin
      send_word(pick_op(), pick_code(), 1'b0, '0);
      n++;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 23);
  end

  always @(posedge clk_i) begin : check_results
    irpdt_pkg::tx_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pin_q.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        exp_res = pin_q.pop_front();
        if (out_pin_level_o !== exp_res.pin_level) begin
          $error("pin_level: expected %0b, got %0b", exp_res.pin_level, out_pin_level_o);
          errors++;
        end
        if (out_busy_res_o !== exp_res.busy_res) begin
          $error("busy_res: expected %0b, got %0b", exp_res.busy_res, out_busy_res_o);
          errors++;
        end
        if (out_frame_done_o !== exp_res.frame_done) begin
          $error("frame_done: expected %0b, got %0b", exp_res.frame_done, out_frame_done_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int k;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < DIR_ROWS; k++)
      send_word(dir_rows[k].op, dir_rows[k].code, dir_rows[k].known, dir_rows[k].res);
    drain_results();

    // zero units act as one; the running half count is already past the new value
    load_cfg(8'd0, 8'd0, 20'hFFFFF);
    run_words(0, 300, 300);
    drain_results();  // hold off mid-frame until all words are back

    steady = 1'b1;
    run_words(0, 300, 300);
    drain_results();
    steady = 1'b0;

    // park in a very long gap, then shorten it below the elapsed count
    run_to_phase(irpdt_pkg::PH_GAP, 2000);
    run_words(0, 20, 20);
    drain_results();
    load_cfg(8'd1, 8'd1, 20'd0);
    run_words(1, 0, 100);
    drain_results();

    run_words(0, 30, 30);
    drain_results();

    repeat (8) @(posedge clk_i);
    if (errors == 0 && pin_q.size() == 0) begin
      $display("** ir_pulse_distance_transmitter: PASSED **");
    end else begin
      $display("** ir_pulse_distance_transmitter: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("** ir_pulse_distance_transmitter: FAILED **");
    $finish;
  end

endmodule
